@@ rtl/core/fdl_pkg.sv @@
// shared types, constants and the crc-16 byte update for the flash download sequencer
// no dependencies
package fdl_pkg;

	localparam int PAGE_BYTES = 128;
	localparam int COUNT_W    = 9;
	localparam logic [COUNT_W-1:0] COUNT_CAP = '1;
	localparam int PAGES_W    = 10;
	localparam int PROD_W     = PAGES_W + $clog2(PAGE_BYTES + 1);

	localparam logic [7:0]  RESP_OFFSET = 8'h40;
	localparam logic [7:0]  RESP_NEG    = 8'h7f;
	localparam logic [15:0] CRC_INIT    = 16'hffff;
	localparam logic [15:0] CRC_POLY    = 16'ha001;

	// default service codes and sub-function
	localparam logic [7:0] DEF_SESSION_SVC  = 8'h10;
	localparam logic [7:0] DEF_PROG_SUBCODE = 8'h02;
	localparam logic [7:0] DEF_DOWNLOAD_SVC = 8'h34;
	localparam logic [7:0] DEF_TRANSFER_SVC = 8'h36;
	localparam logic [7:0] DEF_EXIT_SVC     = 8'h37;
	localparam logic [7:0] DEF_CRC_SVC      = 8'h31;

	typedef enum logic [2:0] {
		PH_SESSION  = 3'd0,
		PH_DOWNLOAD = 3'd1,
		PH_TRANSFER = 3'd2,
		PH_EXIT     = 3'd3,
		PH_CRC      = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		KIND_FILL   = 2'd0,
		KIND_COMMIT = 2'd1,
		KIND_RESP   = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		REG_SESSION_SVC  = 3'd0,
		REG_PROG_SUBCODE = 3'd1,
		REG_DOWNLOAD_SVC = 3'd2,
		REG_TRANSFER_SVC = 3'd3,
		REG_EXIT_SVC     = 3'd4,
		REG_CRC_SVC      = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] session_service;
		logic [7:0] programming_subcode;
		logic [7:0] download_service;
		logic [7:0] transfer_service;
		logic [7:0] exit_service;
		logic [7:0] crc_service;
	} cfg_t;

	// results caused by one request byte, in output order: fill, commit, response
	typedef struct packed {
		logic       has_fill;
		logic       has_commit;
		logic       has_resp;
		logic [6:0] fill_offset;
		logic [7:0] fill_data;
		logic [8:0] page_index;
		logic [7:0] response_byte;
		logic       crc_good;
	} bundle_t;

	function automatic logic [15:0] crc_update(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

@@ rtl/core/fdl_cfg_regs.sv @@
// configuration registers: service codes and programming sub-function
// depends on fdl_pkg
module fdl_cfg_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [7:0]         cfg_data,
	output fdl_pkg::cfg_t      cfg
);

	fdl_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.session_service     <= fdl_pkg::DEF_SESSION_SVC;
			cfg_q.programming_subcode <= fdl_pkg::DEF_PROG_SUBCODE;
			cfg_q.download_service    <= fdl_pkg::DEF_DOWNLOAD_SVC;
			cfg_q.transfer_service    <= fdl_pkg::DEF_TRANSFER_SVC;
			cfg_q.exit_service        <= fdl_pkg::DEF_EXIT_SVC;
			cfg_q.crc_service         <= fdl_pkg::DEF_CRC_SVC;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				fdl_pkg::REG_SESSION_SVC:  cfg_q.session_service     <= cfg_data;
				fdl_pkg::REG_PROG_SUBCODE: cfg_q.programming_subcode <= cfg_data;
				fdl_pkg::REG_DOWNLOAD_SVC: cfg_q.download_service    <= cfg_data;
				fdl_pkg::REG_TRANSFER_SVC: cfg_q.transfer_service    <= cfg_data;
				fdl_pkg::REG_EXIT_SVC:     cfg_q.exit_service        <= cfg_data;
				fdl_pkg::REG_CRC_SVC:      cfg_q.crc_service         <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

@@ rtl/core/fdl_seq.sv @@
// download session state and per-byte decision logic, one word per cycle while accept is high
// depends on fdl_pkg
module fdl_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [7:0]         rx_byte,
	input  logic               end_of_request,
	input  fdl_pkg::cfg_t      cfg,
	output fdl_pkg::bundle_t   bundle
);

	fdl_pkg::phase_t                 phase_q, phase_d;
	logic [fdl_pkg::COUNT_W-1:0]     byte_count_q, byte_count_d;
	logic [7:0]                      service_q, arg_one_q, arg_two_q, arg_three_q;
	logic [7:0]                      svc_n, a1_n, a2_n, a3_n;
	logic [15:0]                     image_size_q, image_size_d;
	logic [fdl_pkg::PAGES_W-1:0]     pages_done_q, pages_done_d;
	logic [fdl_pkg::PAGES_W-1:0]     pages_inc;
	logic [15:0]                     crc_running_q, crc_running_d;
	logic [15:0]                     crc_committed_q, crc_committed_d;
	logic [fdl_pkg::PROD_W-1:0]      done_bytes;
	logic                            fill_en;
	logic [7:0]                      pos;
	logic [fdl_pkg::COUNT_W-1:0]     idx_m1;

	always_comb begin
		svc_n = (byte_count_q == fdl_pkg::COUNT_W'(0)) ? rx_byte : service_q;
		a1_n  = (byte_count_q == fdl_pkg::COUNT_W'(1)) ? rx_byte : arg_one_q;
		a2_n  = (byte_count_q == fdl_pkg::COUNT_W'(2)) ? rx_byte : arg_two_q;
		a3_n  = (byte_count_q == fdl_pkg::COUNT_W'(3)) ? rx_byte : arg_three_q;
		idx_m1 = byte_count_q - fdl_pkg::COUNT_W'(1);

		fill_en = (byte_count_q != fdl_pkg::COUNT_W'(0))
			&& (byte_count_q <= fdl_pkg::COUNT_W'(fdl_pkg::PAGE_BYTES))
			&& (phase_q == fdl_pkg::PH_TRANSFER)
			&& (svc_n == cfg.transfer_service);

		phase_d         = phase_q;
		byte_count_d    = byte_count_q;
		image_size_d    = image_size_q;
		pages_done_d    = pages_done_q;
		crc_running_d   = fill_en ? fdl_pkg::crc_update(crc_running_q, rx_byte) : crc_running_q;
		crc_committed_d = crc_committed_q;
		pos             = svc_n + fdl_pkg::RESP_OFFSET;
		// page count wraps before the size compare
		pages_inc       = pages_done_q + fdl_pkg::PAGES_W'(1);
		done_bytes      = fdl_pkg::PROD_W'(pages_inc) * fdl_pkg::PROD_W'(fdl_pkg::PAGE_BYTES);

		bundle               = '0;
		bundle.has_fill      = fill_en;
		bundle.fill_offset   = fill_en ? idx_m1[6:0] : 7'd0;
		bundle.fill_data     = fill_en ? rx_byte : 8'd0;
		bundle.response_byte = fdl_pkg::RESP_NEG;

		if (!end_of_request) begin
			if (byte_count_q != fdl_pkg::COUNT_CAP) begin
				byte_count_d = byte_count_q + fdl_pkg::COUNT_W'(1);
			end
			bundle.response_byte = 8'd0;
		end else begin
			byte_count_d = '0;
			if (svc_n == cfg.session_service) begin
				bundle.has_resp = 1'b1;
				if (a1_n == cfg.programming_subcode && phase_q == fdl_pkg::PH_SESSION
						&& byte_count_q == fdl_pkg::COUNT_W'(1)) begin
					phase_d = fdl_pkg::PH_DOWNLOAD;
					bundle.response_byte = pos;
				end else begin
					phase_d = fdl_pkg::PH_SESSION;
				end
			end else if (svc_n == cfg.download_service) begin
				bundle.has_resp = 1'b1;
				if (byte_count_q >= fdl_pkg::COUNT_W'(3) && phase_q == fdl_pkg::PH_DOWNLOAD) begin
					image_size_d    = {a2_n, a3_n};
					pages_done_d    = '0;
					crc_running_d   = fdl_pkg::CRC_INIT;
					crc_committed_d = fdl_pkg::CRC_INIT;
					phase_d         = fdl_pkg::PH_TRANSFER;
					bundle.response_byte = pos;
				end else begin
					phase_d = fdl_pkg::PH_DOWNLOAD;
				end
			end else if (svc_n == cfg.transfer_service) begin
				bundle.has_resp = 1'b1;
				if (phase_q == fdl_pkg::PH_TRANSFER
						&& byte_count_q == fdl_pkg::COUNT_W'(fdl_pkg::PAGE_BYTES)) begin
					bundle.has_commit = 1'b1;
					bundle.page_index = pages_done_q[8:0];
					crc_committed_d   = crc_running_d;
					pages_done_d      = pages_inc;
					if (done_bytes == fdl_pkg::PROD_W'(image_size_q)) begin
						phase_d = fdl_pkg::PH_EXIT;
					end else begin
						phase_d = fdl_pkg::PH_TRANSFER;
					end
					bundle.response_byte = pos;
				end else begin
					crc_running_d = crc_committed_q;
					phase_d       = fdl_pkg::PH_TRANSFER;
				end
			end else if (svc_n == cfg.exit_service) begin
				bundle.has_resp = 1'b1;
				if (phase_q == fdl_pkg::PH_EXIT && byte_count_q == fdl_pkg::COUNT_W'(0)) begin
					phase_d = fdl_pkg::PH_CRC;
					bundle.response_byte = pos;
				end else begin
					phase_d = fdl_pkg::PH_EXIT;
				end
			end else if (svc_n == cfg.crc_service) begin
				bundle.has_resp = 1'b1;
				if (phase_q == fdl_pkg::PH_CRC && byte_count_q == fdl_pkg::COUNT_W'(2)) begin
					phase_d = fdl_pkg::PH_DOWNLOAD;
					bundle.response_byte = pos;
					bundle.crc_good = ({a1_n, a2_n} == crc_committed_q);
				end else begin
					phase_d = fdl_pkg::PH_CRC;
				end
			end else begin
				bundle.response_byte = 8'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= fdl_pkg::PH_SESSION;
			byte_count_q    <= '0;
			service_q       <= '0;
			arg_one_q       <= '0;
			arg_two_q       <= '0;
			arg_three_q     <= '0;
			image_size_q    <= '0;
			pages_done_q    <= '0;
			crc_running_q   <= fdl_pkg::CRC_INIT;
			crc_committed_q <= fdl_pkg::CRC_INIT;
		end else if (accept) begin
			phase_q         <= phase_d;
			byte_count_q    <= byte_count_d;
			service_q       <= svc_n;
			arg_one_q       <= a1_n;
			arg_two_q       <= a2_n;
			arg_three_q     <= a3_n;
			image_size_q    <= image_size_d;
			pages_done_q    <= pages_done_d;
			crc_running_q   <= crc_running_d;
			crc_committed_q <= crc_committed_d;
		end
	end

endmodule

@@ rtl/core/fdl_out_queue.sv @@
// two-entry result queue and serializer: one result word per cycle from each stored bundle while rsp_stall is low
// depends on fdl_pkg
module fdl_out_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  fdl_pkg::bundle_t   bundle,
	output logic               full,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [1:0]         kind,
	output logic [6:0]         fill_offset,
	output logic [7:0]         fill_data,
	output logic [8:0]         page_index,
	output logic [7:0]         response_byte,
	output logic               crc_good,
	output logic               last
);

	fdl_pkg::bundle_t entry_q [2];
	logic             wr_ptr_q, rd_ptr_q;
	logic [1:0]       count_q;
	logic [2:0]       sent_q;
	fdl_pkg::bundle_t head;
	logic [2:0]       pend, cur;
	logic             do_push, do_pop, out_take;
	fdl_pkg::kind_t   cur_kind;

	assign full     = (count_q == 2'd2);
	assign do_push  = push && (bundle.has_fill || bundle.has_commit || bundle.has_resp);
	assign head     = entry_q[rd_ptr_q];
	assign rsp_valid = (count_q != 2'd0);
	assign out_take = rsp_valid && !rsp_stall;
	assign do_pop   = out_take && last;

	always_comb begin
		pend = {head.has_resp, head.has_commit, head.has_fill} & ~sent_q;
		if (pend[0]) begin
			cur      = 3'b001;
			cur_kind = fdl_pkg::KIND_FILL;
		end else if (pend[1]) begin
			cur      = 3'b010;
			cur_kind = fdl_pkg::KIND_COMMIT;
		end else begin
			cur      = 3'b100;
			cur_kind = fdl_pkg::KIND_RESP;
		end
		last          = ((pend & ~cur) == 3'b000);
		kind          = cur_kind;
		fill_offset   = cur[0] ? head.fill_offset : 7'd0;
		fill_data     = cur[0] ? head.fill_data : 8'd0;
		page_index    = cur[1] ? head.page_index : 9'd0;
		response_byte = cur[2] ? head.response_byte : 8'd0;
		crc_good      = cur[2] ? head.crc_good : 1'b0;
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= bundle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
			sent_q   <= 3'b000;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
				sent_q   <= 3'b000;
			end else if (out_take) begin
				sent_q <= sent_q | cur;
			end
			count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule

@@ rtl/core/flash_download_session_fsm.sv @@
// flash download session sequencer top level: config registers, sequencer, result queue
// depends on fdl_pkg, fdl_cfg_regs, fdl_seq, fdl_out_queue
// result words of a byte are written into the result queue when the byte is accepted
// throughput: one byte per cycle while each byte gives at most one result word and rsp_stall is low;
// a byte that gives several words sends them one at a time through the single result port
// reset: arst_n clears phase and counters, sets the crc state to CRC_INIT and loads the default service codes
module flash_download_session_fsm (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  logic [7:0] rx_byte,
	input  logic       end_of_request,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output logic [1:0] kind,
	output logic [6:0] fill_offset,
	output logic [7:0] fill_data,
	output logic [8:0] page_index,
	output logic [7:0] response_byte,
	output logic       crc_good,
	output logic       last,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data
);

	fdl_pkg::cfg_t    cfg;
	fdl_pkg::bundle_t bundle;
	logic             full;
	logic             accept;

	assign req_stall = full;
	assign accept    = req_valid && !req_stall;

	fdl_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	fdl_seq u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.rx_byte        (rx_byte),
		.end_of_request (end_of_request),
		.cfg            (cfg),
		.bundle         (bundle)
	);

	fdl_out_queue u_queue (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (accept),
		.bundle        (bundle),
		.full          (full),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.kind          (kind),
		.fill_offset   (fill_offset),
		.fill_data     (fill_data),
		.page_index    (page_index),
		.response_byte (response_byte),
		.crc_good      (crc_good),
		.last          (last)
	);

endmodule

@@ test/tb_flash_download_session_fsm.sv @@
// testbench for flash_download_session_fsm: request words in, fill, commit and response words out
// predicts every result word from its own sequencer model and checks them in order
// depends on fdl_pkg and the rtl of flash_download_session_fsm
`timescale 1ns / 1ps

module tb_flash_download_session_fsm;

	localparam int LIMIT_CYCLES = 300000;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES = 300;

	typedef struct {
		fdl_pkg::kind_t kind;
		logic [6:0]     off;
		logic [7:0]     data;
		logic [8:0]     page;
		logic [7:0]     resp;
		logic           good;
		logic           last;
	} rsp_word_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       req_valid = 1'b0;
	logic       req_stall;
	logic [7:0] rx_byte = 8'h00;
	logic       end_of_request = 1'b0;
	logic       rsp_valid;
	logic       rsp_stall = 1'b0;
	logic [1:0] kind;
	logic [6:0] fill_offset;
	logic [7:0] fill_data;
	logic [8:0] page_index;
	logic [7:0] response_byte;
	logic       crc_good;
	logic       last;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [2:0] cfg_index = 3'd0;
	logic [7:0] cfg_data = 8'h00;

	flash_download_session_fsm u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.rx_byte        (rx_byte),
		.end_of_request (end_of_request),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.kind           (kind),
		.fill_offset    (fill_offset),
		.fill_data      (fill_data),
		.page_index     (page_index),
		.response_byte  (response_byte),
		.crc_good       (crc_good),
		.last           (last),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always #6 clk = ~clk;

	// sequencer shadow state
	fdl_pkg::cfg_t               regs;
	fdl_pkg::phase_t             cur_phase;
	logic [fdl_pkg::COUNT_W-1:0] req_count;
	logic [7:0]                  svc_b, arg1, arg2, arg3;
	logic [15:0]                 img_size;
	logic [fdl_pkg::PAGES_W-1:0] pages_done;
	logic [15:0]                 crc_run, crc_com;

	rsp_word_t pending_words[$];

	int gap_pct = 0;
	int stall_pct = 0;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;
	int failures = 0;
	int cycle_count = 0;
	int bytes_sent = 0;
	int words_checked = 0;
	int commits_seen = 0;
	int crc_matches = 0;
	int images_run = 0;
	int settings_used = 1;

	task automatic reset_model();
		regs = '{session_service: fdl_pkg::DEF_SESSION_SVC,
			programming_subcode: fdl_pkg::DEF_PROG_SUBCODE,
			download_service: fdl_pkg::DEF_DOWNLOAD_SVC,
			transfer_service: fdl_pkg::DEF_TRANSFER_SVC,
			exit_service: fdl_pkg::DEF_EXIT_SVC,
			crc_service: fdl_pkg::DEF_CRC_SVC};
		cur_phase = fdl_pkg::PH_SESSION;
		req_count = '0;
		svc_b = 8'h00;
		arg1 = 8'h00;
		arg2 = 8'h00;
		arg3 = 8'h00;
		img_size = 16'h0000;
		pages_done = '0;
		crc_run = fdl_pkg::CRC_INIT;
		crc_com = fdl_pkg::CRC_INIT;
	endtask

	function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
		c[7:0] = c[7:0] ^ b;
		repeat (8) c = (c >> 1) ^ (c[0] ? fdl_pkg::CRC_POLY : 16'h0000);
		return c;
	endfunction

	function automatic rsp_word_t mk_word(input fdl_pkg::kind_t k, input logic [6:0] off,
			input logic [7:0] d, input logic [8:0] pg, input logic [7:0] r, input logic g);
		rsp_word_t w;
		w.kind = k;
		w.off = off;
		w.data = d;
		w.page = pg;
		w.resp = r;
		w.good = g;
		w.last = 1'b0;
		return w;
	endfunction

	// expected words for one accepted request word
	task automatic apply_request_byte(input logic [7:0] b, input logic eor);
		rsp_word_t  batch[$];
		int         idx;
		logic [7:0] ok_resp;
		idx = int'(req_count);
		case (idx)
			0: svc_b = b;
			1: arg1 = b;
			2: arg2 = b;
			3: arg3 = b;
			default: ;
		endcase
		if (idx >= 1 && idx <= fdl_pkg::PAGE_BYTES && cur_phase == fdl_pkg::PH_TRANSFER &&
				svc_b == regs.transfer_service) begin
			batch.push_back(mk_word(fdl_pkg::KIND_FILL, 7'(idx - 1), b, 9'd0, 8'h00, 1'b0));
			crc_run = crc_step(crc_run, b);
		end
		if (!eor) begin
			if (req_count != fdl_pkg::COUNT_CAP)
				req_count++;
		end else begin
			req_count = '0;
			ok_resp = svc_b + fdl_pkg::RESP_OFFSET;
			if (svc_b == regs.session_service) begin
				if (arg1 == regs.programming_subcode && cur_phase == fdl_pkg::PH_SESSION
						&& idx == 1) begin
					cur_phase = fdl_pkg::PH_DOWNLOAD;
					batch.push_back(mk_word(fdl_pkg::KIND_RESP, 7'd0, 8'h00, 9'd0, ok_resp, 1'b0));
				end else begin
					cur_phase = fdl_pkg::PH_SESSION;
					batch.push_back(mk_word(fdl_pkg::KIND_RESP, 7'd0, 8'h00, 9'd0,
						fdl_pkg::RESP_NEG, 1'b0));
				end
			end else if (svc_b == regs.download_service) begin
				if (idx >= 3 && cur_phase == fdl_pkg::PH_DOWNLOAD) begin
					img_size = {arg2, arg3};
					pages_done = '0;
					crc_run = fdl_pkg::CRC_INIT;
					crc_com = fdl_pkg::CRC_INIT;
					cur_phase = fdl_pkg::PH_TRANSFER;
					batch.push_back(mk_word(fdl_pkg::KIND_RESP, 7'd0, 8'h00, 9'd0, ok_resp, 1'b0));
				end else begin
					cur_phase = fdl_pkg::PH_DOWNLOAD;
					batch.push_back(mk_word(fdl_pkg::KIND_RESP, 7'd0, 8'h00, 9'd0,
						fdl_pkg::RESP_NEG, 1'b0));
				end
			end else if (svc_b == regs.transfer_service) begin
				if (cur_phase == fdl_pkg::PH_TRANSFER && idx == fdl_pkg::PAGE_BYTES) begin
					batch.push_back(mk_word(fdl_pkg::KIND_COMMIT, 7'd0, 8'h00, pages_done[8:0],
						8'h00, 1'b0));
					crc_com = crc_run;
					pages_done++;
					if (int'(pages_done) * fdl_pkg::PAGE_BYTES == int'(img_size))
						cur_phase = fdl_pkg::PH_EXIT;
					else
						cur_phase = fdl_pkg::PH_TRANSFER;
					batch.push_back(mk_word(fdl_pkg::KIND_RESP, 7'd0, 8'h00, 9'd0, ok_resp, 1'b0));
				end else begin
					crc_run = crc_com;
					cur_phase = fdl_pkg::PH_TRANSFER;
					batch.push_back(mk_word(fdl_pkg::KIND_RESP, 7'd0, 8'h00, 9'd0,
						fdl_pkg::RESP_NEG, 1'b0));
				end
			end else if (svc_b == regs.exit_service) begin
				if (cur_phase == fdl_pkg::PH_EXIT && idx == 0) begin
					cur_phase = fdl_pkg::PH_CRC;
					batch.push_back(mk_word(fdl_pkg::KIND_RESP, 7'd0, 8'h00, 9'd0, ok_resp, 1'b0));
				end else begin
					cur_phase = fdl_pkg::PH_EXIT;
					batch.push_back(mk_word(fdl_pkg::KIND_RESP, 7'd0, 8'h00, 9'd0,
						fdl_pkg::RESP_NEG, 1'b0));
				end
			end else if (svc_b == regs.crc_service) begin
				if (cur_phase == fdl_pkg::PH_CRC && idx == 2) begin
					cur_phase = fdl_pkg::PH_DOWNLOAD;
					batch.push_back(mk_word(fdl_pkg::KIND_RESP, 7'd0, 8'h00, 9'd0, ok_resp,
						{arg1, arg2} == crc_com));
				end else begin
					cur_phase = fdl_pkg::PH_CRC;
					batch.push_back(mk_word(fdl_pkg::KIND_RESP, 7'd0, 8'h00, 9'd0,
						fdl_pkg::RESP_NEG, 1'b0));
				end
			end
		end
		if (batch.size() > 0)
			batch[batch.size() - 1].last = 1'b1;
		foreach (batch[i])
			pending_words.push_back(batch[i]);
	endtask

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			failures++;
		end
	endtask

	task automatic check_word();
		rsp_word_t w;
		words_checked++;
		if (pending_words.size() == 0) begin
			$error("result word with nothing expected: kind %0d", kind);
			failures++;
			return;
		end
		w = pending_words.pop_front();
		if (w.kind == fdl_pkg::KIND_COMMIT)
			commits_seen++;
		if (w.good)
			crc_matches++;
		check_field("kind", w.kind, kind);
		check_field("fill_offset", w.off, fill_offset);
		check_field("fill_data", w.data, fill_data);
		check_field("page_index", w.page, page_index);
		check_field("response_byte", w.resp, response_byte);
		check_field("crc_good", w.good, crc_good);
		check_field("last", w.last, last);
	endtask

	// result side: check accepted words, then pick stall for the next cycle
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			check_word();
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("tb_flash_download_session_fsm NOT OK");
			$finish;
		end
	end

	task automatic send_word(input logic [7:0] b, input logic eor);
		if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < gap_pct);
		end
		req_valid <= 1'b1;
		rx_byte <= b;
		end_of_request <= eor;
		do @(posedge clk); while (req_stall);
		apply_request_byte(b, eor);
		bytes_sent++;
	endtask

	task automatic send_short(input int n, input logic [7:0] b0, input logic [7:0] b1,
			input logic [7:0] b2, input logic [7:0] b3, input logic [7:0] b4);
		logic [7:0] v [5];
		v = '{b0, b1, b2, b3, b4};
		for (int i = 0; i < n; i++)
			send_word(v[i], i == n - 1);
	endtask

	// service word followed by random payload
	task automatic send_data_request(input int len, input logic [7:0] svc);
		send_word(svc, len == 1);
		for (int i = 1; i < len; i++)
			send_word(8'($urandom), i == len - 1);
	endtask

	task automatic wait_idle();
		req_valid <= 1'b0;
		do @(posedge clk); while (pending_words.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input fdl_pkg::cfg_reg_t r, input logic [7:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= r;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		case (r)
			fdl_pkg::REG_SESSION_SVC:  regs.session_service = v;
			fdl_pkg::REG_PROG_SUBCODE: regs.programming_subcode = v;
			fdl_pkg::REG_DOWNLOAD_SVC: regs.download_service = v;
			fdl_pkg::REG_TRANSFER_SVC: regs.transfer_service = v;
			fdl_pkg::REG_EXIT_SVC:     regs.exit_service = v;
			fdl_pkg::REG_CRC_SVC:      regs.crc_service = v;
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_all_regs(input logic [7:0] s, input logic [7:0] p, input logic [7:0] d,
			input logic [7:0] t, input logic [7:0] e, input logic [7:0] c);
		wait_idle();
		write_reg(fdl_pkg::REG_SESSION_SVC, s);
		write_reg(fdl_pkg::REG_PROG_SUBCODE, p);
		write_reg(fdl_pkg::REG_DOWNLOAD_SVC, d);
		write_reg(fdl_pkg::REG_TRANSFER_SVC, t);
		write_reg(fdl_pkg::REG_EXIT_SVC, e);
		write_reg(fdl_pkg::REG_CRC_SVC, c);
		settings_used++;
	endtask

	task automatic open_download(input logic [15:0] size);
		while (cur_phase != fdl_pkg::PH_DOWNLOAD)
			send_short(2, regs.session_service, regs.programming_subcode, 8'h00, 8'h00, 8'h00);
		send_short(4, regs.download_service, 8'($urandom), size[15:8], size[7:0], 8'h00);
	endtask

	task automatic send_exit_and_crc(input bit noisy);
		logic [15:0] crc_val;
		if (noisy && $urandom_range(2) == 0)
			send_short(2, regs.exit_service, 8'($urandom), 8'h00, 8'h00, 8'h00);
		send_short(1, regs.exit_service, 8'h00, 8'h00, 8'h00, 8'h00);
		if (noisy && $urandom_range(2) == 0)
			send_short(2, regs.crc_service, 8'($urandom), 8'h00, 8'h00, 8'h00);
		crc_val = crc_com;
		if ($urandom_range(1) == 0)
			crc_val = crc_val ^ 16'($urandom_range(1, 65535));
		send_short(3, regs.crc_service, crc_val[15:8], crc_val[7:0], 8'h00, 8'h00);
	endtask

	// download opened, then a short page that is refused, then exit and crc out of turn
	task automatic run_partial_image(input bit noisy);
		open_download(16'(fdl_pkg::PAGE_BYTES));
		send_data_request($urandom_range(2, 24), regs.transfer_service);
		send_exit_and_crc(noisy);
	endtask

	task automatic noise_requests(input int n);
		logic [7:0] s;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(5))
				0: s = regs.session_service;
				1: s = regs.download_service;
				2: s = regs.transfer_service;
				3: s = regs.exit_service;
				4: s = regs.crc_service;
				default: s = 8'($urandom);
			endcase
			send_data_request($urandom_range(1, 6), s);
		end
	endtask

	task automatic test_out_of_phase();
		send_short(1, regs.exit_service, 8'h00, 8'h00, 8'h00, 8'h00);
		send_short(3, regs.crc_service, 8'h00, 8'hff, 8'h00, 8'h00);
		send_short(2, regs.transfer_service, 8'hff, 8'h00, 8'h00, 8'h00);
	endtask

	task automatic test_unknown_service();
		send_short(2, 8'h00, 8'hff, 8'h00, 8'h00, 8'h00);
		send_short(1, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00);
	endtask

	task automatic test_session_rules();
		// short request keeps the old argument
		send_short(1, regs.session_service, 8'h00, 8'h00, 8'h00, 8'h00);
		send_short(3, regs.session_service, regs.programming_subcode, 8'h00, 8'h00, 8'h00);
		send_short(2, regs.session_service, ~regs.programming_subcode, 8'h00, 8'h00, 8'h00);
		send_short(2, regs.session_service, regs.programming_subcode, 8'h00, 8'h00, 8'h00);
	endtask

	task automatic test_download_rules();
		send_short(3, regs.download_service, 8'h00, 8'hff, 8'h00, 8'h00);
		send_short(5, regs.download_service, 8'hff, 8'hff, 8'hff, 8'h00);
	endtask

	task automatic test_random_images(input int gap, input int stall);
		gap_pct = gap;
		stall_pct = stall;
		noise_requests(3);
		run_partial_image(1'b1);
	endtask

	task automatic test_register_extremes();
		write_all_regs(8'h00, 8'hff, 8'hff, 8'h80, 8'h01, 8'hc0);
		noise_requests(4);
		run_partial_image(1'b0);
	endtask

	task automatic test_overlapping_services();
		wait_idle();
		write_reg(fdl_pkg::REG_DOWNLOAD_SVC, regs.session_service);
		write_reg(fdl_pkg::REG_TRANSFER_SVC, regs.session_service);
		write_reg(fdl_pkg::REG_CRC_SVC, regs.exit_service);
		settings_used++;
		send_short(2, regs.session_service, regs.programming_subcode, 8'h00, 8'h00, 8'h00);
		send_short(4, regs.session_service, 8'h12, 8'h34, 8'h56, 8'h00);
		send_short(1, regs.exit_service, 8'h00, 8'h00, 8'h00, 8'h00);
		send_short(3, regs.exit_service, 8'hab, 8'hcd, 8'h00, 8'h00);
		noise_requests(4);
		write_all_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom));
		noise_requests(4);
		write_all_regs(fdl_pkg::DEF_SESSION_SVC, fdl_pkg::DEF_PROG_SUBCODE,
			fdl_pkg::DEF_DOWNLOAD_SVC, fdl_pkg::DEF_TRANSFER_SVC, fdl_pkg::DEF_EXIT_SVC,
			fdl_pkg::DEF_CRC_SVC);
	endtask

	// one whole page download while the result side holds off, then exit and crc check
	task automatic test_backpressure();
		gap_pct = 0;
		stall_pct = 0;
		open_download(16'(fdl_pkg::PAGE_BYTES));
		hold_requests++;
		send_data_request(fdl_pkg::PAGE_BYTES + 1, regs.transfer_service);
		wait_idle();
		send_exit_and_crc(1'b0);
		images_run++;
	endtask

	initial begin
		reset_model();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);
		test_out_of_phase();
		test_unknown_service();
		test_session_rules();
		test_download_rules();
		test_random_images(0, 0);
		test_random_images(71, 0);
		test_random_images(0, 71);
		test_random_images(21, 21);
		test_register_extremes();
		test_overlapping_services();
		test_backpressure();
		wait_idle();
		$display("sent %0d request words and checked %0d result words, %0d page commits",
			bytes_sent, words_checked, commits_seen);
		$display("%0d full downloads over %0d register settings, %0d crc checks matched",
			images_run, settings_used, crc_matches);
		if (failures == 0 && pending_words.size() == 0) begin
			$display("tb_flash_download_session_fsm OK");
		end else begin
			$display("tb_flash_download_session_fsm NOT OK");
		end
		$finish;
	end

endmodule
